### rtl/psta_pkg.sv
package psta_pkg;

   localparam int THREADS      = 16;
   localparam int TOP_PRIORITY = 7;
   localparam int SLOT_W       = $clog2(THREADS);
   localparam int LINK_W       = SLOT_W + 1;
   localparam int PRI_W        = $clog2(TOP_PRIORITY + 1);
   localparam int CSR_AW       = 4;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(THREADS);

   localparam logic [2:0] ST_FREE     = 3'd0;
   localparam logic [2:0] ST_READY    = 3'd1;
   localparam logic [2:0] ST_RUNNING  = 3'd2;
   localparam logic [2:0] ST_SLEEPING = 3'd3;
   localparam logic [2:0] ST_DEAD     = 3'd4;

   localparam logic [2:0] OP_SPAWN  = 3'd0;
   localparam logic [2:0] OP_RESCHED = 3'd1;
   localparam logic [2:0] OP_SLEEP  = 3'd2;
   localparam logic [2:0] OP_EXIT   = 3'd3;
   localparam logic [2:0] OP_QUERY  = 3'd4;

   localparam logic [1:0] REG_AGING_LIMIT = 2'd0;
   localparam logic [1:0] REG_SLICE_UNIT  = 2'd1;
   localparam logic [1:0] REG_MS_PER_TICK = 2'd2;

   typedef struct packed {
      logic [31:0]       tid;
      logic [PRI_W-1:0]  pri;
      logic [2:0]        status;
      logic [7:0]        slice;
      logic [7:0]        age;
      logic [LINK_W-1:0] link;
      logic [63:0]       wake;
      logic [63:0]       ctx;
   } slot_type;

   function automatic logic [7:0] slice_for(input logic [PRI_W-1:0] p, input logic [3:0] unit);
      logic [PRI_W:0]   inv;
      logic [PRI_W+4:0] v;
      inv = (PRI_W+1)'(TOP_PRIORITY + 1) - {1'b0, p};
      v   = (PRI_W+5)'(inv) * (PRI_W+5)'(unit);
      return (v > (PRI_W+5)'(255)) ? 8'hFF : v[7:0];
   endfunction

endpackage

### rtl/psta_div.sv
module psta_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [7:0]  divisor,
   output logic        busy,
   output logic [31:0] quotient
);

   logic [31:0] quo_ff, quo_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [8:0]  trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[31]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 8'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[7:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

### rtl/priority_thread_scheduler_aging.sv
// Thread scheduler with per-priority ready lists, a sleep list and aging. One request is
// handled at a time; the slot table sits in a synchronous memory with one write port and one
// read port, and every slot read passes through S_RD (address, then read data). Spawn and
// query scan the table; sleep waits on a serial divider. A reschedule walks the sleep list,
// the ready lists below the top level and, on a switch that requeues the old thread, its
// ready list to the tail. A finished result is held in the rsp register until taken; the
// next request is taken once the result is loaded there.
module priority_thread_scheduler_aging (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [199:0]                req_tdata,  // priority_req, context_word, now_tick, sleep_ms, query_tid
   input  logic [2:0]                  req_tuser,  // operation
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [103:0]                rsp_tdata,  // status, thread_tid, run_context, switched, alive, slot_freed
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [psta_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   typedef enum logic [20:0] {
      S_IDLE     = 21'd1 << 0,
      S_RD       = 21'd1 << 1,
      S_SPAWN_EX = 21'd1 << 2,
      S_QRY_EX   = 21'd1 << 3,
      S_MARK_EX  = 21'd1 << 4,
      S_SAVE_EX  = 21'd1 << 5,
      S_WAKE_EX  = 21'd1 << 6,
      S_WAKE_FIX = 21'd1 << 7,
      S_AGE_LVL  = 21'd1 << 8,
      S_AGE_EX   = 21'd1 << 9,
      S_AGE_FIX  = 21'd1 << 10,
      S_PICK     = 21'd1 << 11,
      S_NX_EX    = 21'd1 << 12,
      S_R_UPD    = 21'd1 << 13,
      S_TAIL_EX  = 21'd1 << 14,
      S_FIN      = 21'd1 << 15,
      S_DONE     = 21'd1 << 16
   } state_type;

   localparam int SW = psta_pkg::SLOT_W;
   localparam int LW = psta_pkg::LINK_W;
   localparam int PW = psta_pkg::PRI_W;
   localparam int TP = psta_pkg::TOP_PRIORITY;

   psta_pkg::slot_type slot_mem [psta_pkg::THREADS];
   logic [psta_pkg::THREADS-1:0] vld_ff;
   psta_pkg::slot_type mem_q_ff;
   logic               vld_q_ff;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [LW-1:0] cur_ff, cur_in, prev_ff, prev_in, shead_ff, shead_in;
   logic [LW-1:0] head_ff [TP+1];
   logic [LW-1:0] head_in [TP+1];
   psta_pkg::slot_type prevrec_ff, prevrec_in, rrec_ff, rrec_in, nxrec_ff, nxrec_in;
   logic [SW-1:0] run_ff, run_in, nx_ff, nx_in;
   logic [31:0]   tidc_ff, tidc_in;
   logic [PW-1:0] lvl_ff, lvl_in, pp_ff, pp_in;
   logic [2:0]    op_ff, op_in;
   logic [PW-1:0] pri_ff, pri_in;
   logic [63:0]   ctx_ff, ctx_in, now_ff, now_in;
   logic [31:0]   qtid_ff, qtid_in;
   logic          o_status_ff, o_status_in, o_sw_ff, o_sw_in;
   logic          o_alive_ff, o_alive_in, o_freed_ff, o_freed_in;
   logic [31:0]   o_tid_ff, o_tid_in;
   logic [63:0]   o_ctx_ff, o_ctx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [103:0]  rsp_data_ff, rsp_data_in;
   logic [7:0]    aging_limit_ff, ms_per_tick_ff;
   logic [3:0]    slice_unit_ff;

   psta_pkg::slot_type rec_c, w_c, wd_c;
   logic          we_c;
   logic [SW-1:0] wa_c;
   logic [LW-1:0] nxt_c;
   logic [PW-1:0] pick_c, np_c;
   logic          pick_ok_c, preempt_c, accept_c, csr_wr_c;
   logic          div_start_c, div_busy;
   logic [31:0]   div_q;
   logic [7:0]    div_dvs_c;

   psta_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_c),
      .dividend (req_tdata[167:136]),
      .divisor  (div_dvs_c),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign req_tready  = (state_ff == S_IDLE);
   assign accept_c    = req_tvalid && req_tready;
   assign div_start_c = accept_c && (req_tuser == psta_pkg::OP_SLEEP);
   assign div_dvs_c   = (ms_per_tick_ff == 8'd0) ? 8'd1 : ms_per_tick_ff;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;
   assign csr_pready  = 1'b1;
   assign csr_wr_c    = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[3:2])
         psta_pkg::REG_AGING_LIMIT: csr_prdata = {24'd0, aging_limit_ff};
         psta_pkg::REG_SLICE_UNIT:  csr_prdata = {28'd0, slice_unit_ff};
         psta_pkg::REG_MS_PER_TICK: csr_prdata = {24'd0, ms_per_tick_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // unwritten slots read as their reset contents
   always_comb begin
      if (vld_q_ff) begin
         rec_c = mem_q_ff;
      end else begin
         rec_c      = '0;
         rec_c.link = psta_pkg::NIL;
         if (cur_ff[SW-1:0] == '0) begin
            rec_c.tid    = 32'd1;
            rec_c.status = psta_pkg::ST_RUNNING;
         end
      end
   end

   always_comb begin
      pick_c    = '0;
      pick_ok_c = 1'b0;
      for (int p = 0; p <= TP; p++) begin
         if (head_ff[p] != psta_pkg::NIL) begin
            pick_c    = PW'(p);
            pick_ok_c = 1'b1;
         end
      end
      preempt_c = pick_ok_c && ((pick_c > rrec_ff.pri) ||
                  (pick_c == rrec_ff.pri && rrec_ff.slice == 8'd0) ||
                  (rrec_ff.status != psta_pkg::ST_RUNNING));
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      shead_in    = shead_ff;
      head_in     = head_ff;
      prevrec_in  = prevrec_ff;
      rrec_in     = rrec_ff;
      nxrec_in    = nxrec_ff;
      run_in      = run_ff;
      nx_in       = nx_ff;
      tidc_in     = tidc_ff;
      lvl_in      = lvl_ff;
      pp_in       = pp_ff;
      op_in       = op_ff;
      pri_in      = pri_ff;
      ctx_in      = ctx_ff;
      now_in      = now_ff;
      qtid_in     = qtid_ff;
      o_status_in = o_status_ff;
      o_sw_in     = o_sw_ff;
      o_alive_in  = o_alive_ff;
      o_freed_in  = o_freed_ff;
      o_tid_in    = o_tid_ff;
      o_ctx_in    = o_ctx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      we_c        = 1'b0;
      wa_c        = cur_ff[SW-1:0];
      wd_c        = rec_c;
      w_c         = rec_c;
      nxt_c       = rec_c.link;
      np_c        = rec_c.pri;

      case (state_ff)
         S_IDLE: begin
            if (accept_c) begin
               op_in       = req_tuser;
               pri_in      = (req_tdata[7:0] > 8'(TP)) ? PW'(TP) : req_tdata[PW-1:0];
               ctx_in      = req_tdata[71:8];
               now_in      = req_tdata[135:72];
               qtid_in     = req_tdata[199:168];
               o_status_in = 1'b0;
               o_sw_in     = 1'b0;
               o_alive_in  = 1'b0;
               o_freed_in  = 1'b0;
               o_tid_in    = '0;
               o_ctx_in    = '0;
               state_in    = S_RD;
               case (req_tuser)
                  psta_pkg::OP_SPAWN: begin
                     cur_in = '0;
                     ret_in = S_SPAWN_EX;
                  end
                  psta_pkg::OP_RESCHED: begin
                     cur_in = {1'b0, run_ff};
                     ret_in = S_SAVE_EX;
                  end
                  psta_pkg::OP_SLEEP, psta_pkg::OP_EXIT: begin
                     cur_in = {1'b0, run_ff};
                     ret_in = S_MARK_EX;
                  end
                  psta_pkg::OP_QUERY: begin
                     cur_in = '0;
                     ret_in = S_QRY_EX;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_RD: state_in = ret_ff;
         S_SPAWN_EX: begin
            if (rec_c.status == psta_pkg::ST_FREE) begin
               w_c.tid    = tidc_ff;
               w_c.ctx    = ctx_ff;
               w_c.status = psta_pkg::ST_READY;
               w_c.pri    = pri_ff;
               w_c.slice  = psta_pkg::slice_for(pri_ff, slice_unit_ff);
               w_c.age    = '0;
               w_c.link   = head_ff[pri_ff];
               we_c       = 1'b1;
               wd_c       = w_c;
               head_in[pri_ff] = cur_ff;
               tidc_in    = tidc_ff + 32'd1;
               o_tid_in   = tidc_ff;
               state_in   = S_DONE;
            end else if (cur_ff == LW'(psta_pkg::THREADS - 1)) begin
               o_status_in = 1'b1;
               state_in    = S_DONE;
            end else begin
               cur_in   = cur_ff + LW'(1);
               state_in = S_RD;
            end
         end
         S_QRY_EX: begin
            if (rec_c.tid == qtid_ff && (cur_ff == {1'b0, run_ff} ||
                rec_c.status == psta_pkg::ST_READY || rec_c.status == psta_pkg::ST_SLEEPING)) begin
               o_alive_in = 1'b1;
            end
            if (cur_ff == LW'(psta_pkg::THREADS - 1)) begin
               state_in = S_DONE;
            end else begin
               cur_in   = cur_ff + LW'(1);
               state_in = S_RD;
            end
         end
         S_MARK_EX: begin
            if (op_ff == psta_pkg::OP_EXIT) begin
               w_c.status = psta_pkg::ST_DEAD;
               we_c       = 1'b1;
               wd_c       = w_c;
               state_in   = S_DONE;
            end else if (!div_busy) begin
               w_c.status = psta_pkg::ST_SLEEPING;
               w_c.wake   = now_ff + {32'd0, div_q};
               we_c       = 1'b1;
               wd_c       = w_c;
               state_in   = S_DONE;
            end
         end
         S_SAVE_EX: begin
            w_c.ctx = ctx_ff;
            if (rec_c.slice != 8'd0) w_c.slice = rec_c.slice - 8'd1;
            we_c    = 1'b1;
            wd_c    = w_c;
            rrec_in = w_c;
            prev_in = psta_pkg::NIL;
            cur_in  = shead_ff;
            lvl_in  = '0;
            if (shead_ff == psta_pkg::NIL) begin
               state_in = S_AGE_LVL;
            end else begin
               ret_in   = S_WAKE_EX;
               state_in = S_RD;
            end
         end
         S_WAKE_EX: begin
            cur_in = nxt_c;
            state_in = (nxt_c == psta_pkg::NIL) ? S_AGE_LVL : S_RD;
            if (now_ff >= rec_c.wake) begin
               w_c.status = psta_pkg::ST_READY;
               w_c.link   = head_ff[rec_c.pri];
               we_c       = 1'b1;
               wd_c       = w_c;
               head_in[rec_c.pri] = cur_ff;
               if (prev_ff == psta_pkg::NIL) begin
                  shead_in = nxt_c;
               end else begin
                  prevrec_in.link = nxt_c;
                  state_in        = S_WAKE_FIX;
               end
            end else begin
               prev_in    = cur_ff;
               prevrec_in = rec_c;
            end
         end
         S_WAKE_FIX: begin
            we_c     = 1'b1;
            wa_c     = prev_ff[SW-1:0];
            wd_c     = prevrec_ff;
            state_in = (cur_ff == psta_pkg::NIL) ? S_AGE_LVL : S_RD;
         end
         S_AGE_LVL: begin
            prev_in = psta_pkg::NIL;
            cur_in  = head_ff[lvl_ff];
            if (lvl_ff == PW'(TP)) begin
               state_in = S_PICK;
            end else if (head_ff[lvl_ff] == psta_pkg::NIL) begin
               lvl_in = lvl_ff + PW'(1);
            end else begin
               ret_in   = S_AGE_EX;
               state_in = S_RD;
            end
         end
         S_AGE_EX: begin
            cur_in = nxt_c;
            if (nxt_c == psta_pkg::NIL) begin
               lvl_in   = lvl_ff + PW'(1);
               state_in = S_AGE_LVL;
            end else begin
               state_in = S_RD;
            end
            if (cur_ff == '0) begin
               prev_in    = cur_ff;
               prevrec_in = rec_c;
            end else begin
               if (rec_c.age != 8'hFF) w_c.age = rec_c.age + 8'd1;
               we_c = 1'b1;
               if (w_c.age > aging_limit_ff) begin
                  np_c      = (rec_c.pri == PW'(TP)) ? rec_c.pri : rec_c.pri + PW'(1);
                  w_c.age   = '0;
                  w_c.pri   = np_c;
                  w_c.link  = head_ff[np_c];
                  if (prev_ff == psta_pkg::NIL) begin
                     head_in[lvl_ff] = nxt_c;
                  end else begin
                     prevrec_in.link = nxt_c;
                     state_in        = S_AGE_FIX;
                  end
                  head_in[np_c] = cur_ff;
               end else begin
                  prev_in    = cur_ff;
                  prevrec_in = w_c;
               end
               wd_c = w_c;
            end
         end
         S_AGE_FIX: begin
            we_c = 1'b1;
            wa_c = prev_ff[SW-1:0];
            wd_c = prevrec_ff;
            if (cur_ff == psta_pkg::NIL) begin
               state_in = S_AGE_LVL;
            end else begin
               state_in = S_RD;
            end
         end
         S_PICK: begin
            if (preempt_c) begin
               cur_in   = head_ff[pick_c];
               pp_in    = pick_c;
               ret_in   = S_NX_EX;
               state_in = S_RD;
            end else begin
               o_tid_in = rrec_ff.tid;
               o_ctx_in = rrec_ff.ctx;
               state_in = S_DONE;
            end
         end
         S_NX_EX: begin
            head_in[pp_ff] = rec_c.link;
            w_c.status = psta_pkg::ST_RUNNING;
            w_c.link   = psta_pkg::NIL;
            we_c       = 1'b1;
            wd_c       = w_c;
            nxrec_in   = w_c;
            nx_in      = cur_ff[SW-1:0];
            o_sw_in    = 1'b1;
            state_in   = S_R_UPD;
         end
         S_R_UPD: begin
            w_c      = rrec_ff;
            wa_c     = run_ff;
            state_in = S_FIN;
            case (rrec_ff.status)
               psta_pkg::ST_RUNNING: begin
                  w_c.status = psta_pkg::ST_READY;
                  w_c.slice  = psta_pkg::slice_for(rrec_ff.pri, slice_unit_ff);
                  w_c.link   = psta_pkg::NIL;
                  we_c       = 1'b1;
                  if (head_ff[rrec_ff.pri] == psta_pkg::NIL) begin
                     head_in[rrec_ff.pri] = {1'b0, run_ff};
                  end else begin
                     cur_in   = head_ff[rrec_ff.pri];
                     ret_in   = S_TAIL_EX;
                     state_in = S_RD;
                  end
               end
               psta_pkg::ST_SLEEPING: begin
                  w_c.link = shead_ff;
                  shead_in = {1'b0, run_ff};
                  we_c     = 1'b1;
               end
               psta_pkg::ST_DEAD: begin
                  if (rrec_ff.pri != '0) begin
                     w_c.status = psta_pkg::ST_FREE;
                     w_c.link   = psta_pkg::NIL;
                     we_c       = 1'b1;
                     o_freed_in = 1'b1;
                  end
               end
               default: ;
            endcase
            wd_c = w_c;
         end
         S_TAIL_EX: begin
            if (rec_c.link == psta_pkg::NIL) begin
               w_c.link = {1'b0, run_ff};
               we_c     = 1'b1;
               wd_c     = w_c;
               state_in = S_FIN;
            end else begin
               cur_in   = rec_c.link;
               state_in = S_RD;
            end
         end
         S_FIN: begin
            run_in   = nx_ff;
            o_tid_in = nxrec_ff.tid;
            o_ctx_in = nxrec_ff.ctx;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, o_freed_ff, o_alive_ff, o_sw_ff, o_ctx_ff, o_tid_ff,
                               o_status_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_c) slot_mem[wa_c] <= wd_c;
      mem_q_ff <= slot_mem[cur_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         ret_ff         <= S_IDLE;
         vld_ff         <= '0;
         vld_q_ff       <= 1'b0;
         shead_ff       <= psta_pkg::NIL;
         for (int p = 0; p <= TP; p++) head_ff[p] <= psta_pkg::NIL;
         run_ff         <= '0;
         tidc_ff        <= 32'd2;
         rsp_valid_ff   <= 1'b0;
         aging_limit_ff <= 8'd19;
         slice_unit_ff  <= 4'd2;
         ms_per_tick_ff <= 8'd10;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         if (we_c) vld_ff[wa_c] <= 1'b1;
         vld_q_ff     <= vld_ff[cur_ff[SW-1:0]];
         shead_ff     <= shead_in;
         head_ff      <= head_in;
         run_ff       <= run_in;
         tidc_ff      <= tidc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_c) begin
            case (csr_paddr[3:2])
               psta_pkg::REG_AGING_LIMIT: aging_limit_ff <= csr_pwdata[7:0];
               psta_pkg::REG_SLICE_UNIT:  slice_unit_ff  <= csr_pwdata[3:0];
               psta_pkg::REG_MS_PER_TICK: ms_per_tick_ff <= csr_pwdata[7:0];
               default: ;
            endcase
         end
      end
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      prevrec_ff  <= prevrec_in;
      rrec_ff     <= rrec_in;
      nxrec_ff    <= nxrec_in;
      nx_ff       <= nx_in;
      lvl_ff      <= lvl_in;
      pp_ff       <= pp_in;
      op_ff       <= op_in;
      pri_ff      <= pri_in;
      ctx_ff      <= ctx_in;
      now_ff      <= now_in;
      qtid_ff     <= qtid_in;
      o_status_ff <= o_status_in;
      o_sw_ff     <= o_sw_in;
      o_alive_ff  <= o_alive_in;
      o_freed_ff  <= o_freed_in;
      o_tid_ff    <= o_tid_in;
      o_ctx_ff    <= o_ctx_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int THREADS      = psta_pkg::THREADS;
   localparam int TOP_PRIORITY = psta_pkg::TOP_PRIORITY;
   localparam int AW           = psta_pkg::CSR_AW;
   localparam logic [2:0] OP_RSV5 = 3'd5;
   localparam logic [2:0] OP_RSV6 = 3'd6;
   localparam logic [2:0] OP_RSV7 = 3'd7;
   localparam int HOLD_CYCLES = 600;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [199:0] req_tdata = '0;  // priority_req, context_word, now_tick, sleep_ms, query_tid
   logic [2:0]   req_tuser = '0;  // operation
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;       // status, thread_tid, run_context, switched, alive, slot_freed
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [AW-1:0] csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   priority_thread_scheduler_aging dut (.*);

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   typedef struct {
      logic        status;
      logic [31:0] tid;
      logic [63:0] ctx;
      logic        switched;
      logic        alive;
      logic        freed;
   } sched_result_type;

   typedef struct {
      logic [2:0]  op;
      logic [7:0]  pri;
      logic [63:0] ctx;
      logic [63:0] now;
      logic [31:0] ms;
      logic [31:0] qtid;
      bit          typed;
      logic        status;
      logic [31:0] tid;
      logic        alive;
   } sched_row_type;

   // scheduler state mirror
   logic [31:0] th_tid[THREADS];
   int          th_pri[THREADS];
   logic [2:0]  th_st[THREADS];
   int          th_slice[THREADS];
   int          th_age[THREADS];
   logic [63:0] th_wake[THREADS];
   logic [63:0] th_ctx[THREADS];
   int          th_link[THREADS];
   int          rdy_head[TOP_PRIORITY+1];
   int          sleep_list;
   int          cur_slot;
   logic [31:0] tid_counter;
   int          lim_age, unit_slice, ms_div;

   sched_result_type pending_results[$];
   int errors = 0;
   int gap_pct = 0, stall_pct = 0;
   bit hold_req = 0;
   int hold_left = 0;
   bit hold_done = 0;
   int n_items = 0, n_switch = 0, n_freed = 0, n_full = 0;
   logic [63:0] sys_tick = 0;

   function automatic int slice_len(int p);
      int v;
      v = (TOP_PRIORITY - p + 1) * unit_slice;
      return v > 255 ? 255 : v;
   endfunction

   function automatic void ready_push(int s);
      th_link[s] = rdy_head[th_pri[s]];
      rdy_head[th_pri[s]] = s;
   endfunction

   function automatic void ready_append(int s);
      int last;
      int n;
      last = rdy_head[th_pri[s]];
      n = 0;
      th_link[s] = psta_pkg::NIL;
      if (last == psta_pkg::NIL) begin
         rdy_head[th_pri[s]] = s;
         return;
      end
      while (th_link[last] != psta_pkg::NIL && n++ < THREADS) last = th_link[last];
      th_link[last] = s;
   endfunction

   function automatic void wake_due(logic [63:0] now);
      int prv, c, nxt, n;
      prv = psta_pkg::NIL; c = sleep_list; n = 0;
      while (c != psta_pkg::NIL && n++ < THREADS) begin
         nxt = th_link[c];
         if (now >= th_wake[c]) begin
            if (prv != psta_pkg::NIL) th_link[prv] = nxt;
            else sleep_list = nxt;
            th_st[c] = psta_pkg::ST_READY;
            ready_push(c);
         end else begin
            prv = c;
         end
         c = nxt;
      end
   endfunction

   function automatic void age_waiting();
      int prv, c, nxt, n;
      for (int p = 0; p < TOP_PRIORITY; p++) begin
         prv = psta_pkg::NIL; c = rdy_head[p]; n = 0;
         while (c != psta_pkg::NIL && n++ < THREADS) begin
            nxt = th_link[c];
            if (c == 0) begin
               prv = c;
            end else begin
               if (th_age[c] < 255) th_age[c]++;
               if (th_age[c] > lim_age) begin
                  th_age[c] = 0;
                  if (prv != psta_pkg::NIL) th_link[prv] = nxt;
                  else rdy_head[p] = nxt;
                  if (th_pri[c] < TOP_PRIORITY) th_pri[c]++;
                  ready_push(c);
               end else begin
                  prv = c;
               end
            end
            c = nxt;
         end
      end
   endfunction

   function automatic sched_result_type sched_predict(logic [2:0] op, logic [7:0] pri,
         logic [63:0] ctx, logic [63:0] now, logic [31:0] ms, logic [31:0] qtid);
      sched_result_type res;
      int r, s, p, nx;
      res = '{default: '0};
      r = cur_slot;
      case (op)
         psta_pkg::OP_SPAWN: begin
            p = pri > TOP_PRIORITY ? TOP_PRIORITY : int'(pri);
            s = psta_pkg::NIL;
            for (int i = 0; i < THREADS; i++)
               if (s == psta_pkg::NIL && th_st[i] == psta_pkg::ST_FREE) s = i;
            if (s == psta_pkg::NIL) begin
               res.status = 1'b1;
            end else begin
               th_tid[s] = tid_counter;
               tid_counter++;
               th_ctx[s] = ctx;
               th_st[s] = psta_pkg::ST_READY;
               th_pri[s] = p;
               th_slice[s] = slice_len(p);
               th_age[s] = 0;
               ready_push(s);
               res.tid = th_tid[s];
            end
         end
         psta_pkg::OP_RESCHED: begin
            th_ctx[r] = ctx;
            wake_due(now);
            if (th_slice[r] > 0) th_slice[r]--;
            age_waiting();
            for (p = TOP_PRIORITY; p >= 0; p--) begin
               if (rdy_head[p] != psta_pkg::NIL) begin
                  if (p > th_pri[r] || (p == th_pri[r] && th_slice[r] == 0) ||
                        th_st[r] != psta_pkg::ST_RUNNING) begin
                     nx = rdy_head[p];
                     rdy_head[p] = th_link[nx];
                     if (th_st[r] == psta_pkg::ST_RUNNING) begin
                        th_st[r] = psta_pkg::ST_READY;
                        th_slice[r] = slice_len(th_pri[r]);
                        ready_append(r);
                     end else if (th_st[r] == psta_pkg::ST_SLEEPING) begin
                        th_link[r] = sleep_list;
                        sleep_list = r;
                     end else if (th_st[r] == psta_pkg::ST_DEAD && th_pri[r] != 0) begin
                        th_st[r] = psta_pkg::ST_FREE;
                        th_link[r] = psta_pkg::NIL;
                        res.freed = 1'b1;
                     end
                     th_st[nx] = psta_pkg::ST_RUNNING;
                     th_link[nx] = psta_pkg::NIL;
                     cur_slot = nx;
                     res.switched = 1'b1;
                  end
                  break;
               end
            end
            res.tid = th_tid[cur_slot];
            res.ctx = th_ctx[cur_slot];
         end
         psta_pkg::OP_SLEEP: begin
            th_st[r] = psta_pkg::ST_SLEEPING;
            th_wake[r] = now + 64'(ms / (ms_div == 0 ? 1 : ms_div));
         end
         psta_pkg::OP_EXIT: th_st[r] = psta_pkg::ST_DEAD;
         psta_pkg::OP_QUERY: begin
            res.alive = (th_tid[r] == qtid);
            for (int i = 0; i < THREADS; i++)
               if (i != r && (th_st[i] == psta_pkg::ST_READY ||
                     th_st[i] == psta_pkg::ST_SLEEPING) &&
                     th_tid[i] == qtid) res.alive = 1'b1;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic send_request(logic [2:0] op, logic [7:0] pri, logic [63:0] ctx,
         logic [63:0] now, logic [31:0] ms, logic [31:0] qtid, bit typed,
         sched_result_type typed_res);
      sched_result_type res;
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {qtid, ms, now, ctx, pri};
      do @(posedge clock); while (!req_tready);
      res = sched_predict(op, pri, ctx, now, ms, qtid);
      n_items++;
      n_switch += res.switched;
      n_freed += res.freed;
      n_full += res.status;
      pending_results.push_back(typed ? typed_res : res);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= AW'(idx) << 2;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         psta_pkg::REG_AGING_LIMIT: lim_age = val[7:0];
         psta_pkg::REG_SLICE_UNIT:  unit_slice = val[3:0];
         default:                   ms_div = val[7:0];
      endcase
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic random_requests(int count);
      int k, sel;
      logic [2:0]  op;
      logic [7:0]  pri;
      logic [63:0] ctx;
      logic [31:0] ms, qtid;
      sched_result_type none;
      none = '{default: '0};
      for (k = 0; k < count; k++) begin
         sel = $urandom_range(99);
         if (sel < 25) op = psta_pkg::OP_SPAWN;
         else if (sel < 70) op = psta_pkg::OP_RESCHED;
         else if (sel < 78) op = psta_pkg::OP_SLEEP;
         else if (sel < 86) op = psta_pkg::OP_EXIT;
         else if (sel < 98) op = psta_pkg::OP_QUERY;
         else op = 3'($urandom_range(OP_RSV5, OP_RSV7));
         pri = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(TOP_PRIORITY));
         ctx = {$urandom, $urandom};
         ms = ($urandom_range(15) == 0) ? $urandom : 32'($urandom_range(200));
         qtid = ($urandom_range(7) == 0) ? $urandom : tid_counter - $urandom_range(20);
         if ($urandom_range(199) == 0) sys_tick = {$urandom, $urandom};
         else sys_tick += $urandom_range(3);
         if (k == 50 && !hold_done) hold_req <= 1'b1;
         send_request(op, pri, ctx, sys_tick, ms, qtid, 0, none);
      end
      drain();
   endtask

   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[0] !== want.status) begin
               $display("%0t: status exp %0d got %0d", $time, want.status, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[32:1] !== want.tid) begin
               $display("%0t: tid exp %0d got %0d", $time, want.tid, rsp_tdata[32:1]);
               errors++;
            end
            if (rsp_tdata[96:33] !== want.ctx) begin
               $display("%0t: context exp %h got %h", $time, want.ctx, rsp_tdata[96:33]);
               errors++;
            end
            if (rsp_tdata[97] !== want.switched) begin
               $display("%0t: switched exp %0d got %0d", $time, want.switched, rsp_tdata[97]);
               errors++;
            end
            if (rsp_tdata[98] !== want.alive) begin
               $display("%0t: alive exp %0d got %0d", $time, want.alive, rsp_tdata[98]);
               errors++;
            end
            if (rsp_tdata[99] !== want.freed) begin
               $display("%0t: freed exp %0d got %0d", $time, want.freed, rsp_tdata[99]);
               errors++;
            end
         end
      end
      if (hold_req && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      sched_row_type rows[];
      sched_result_type typed_res;
      for (int i = 0; i < THREADS; i++) begin
         th_tid[i] = 0; th_pri[i] = 0; th_st[i] = psta_pkg::ST_FREE; th_slice[i] = 0;
         th_age[i] = 0; th_wake[i] = 0; th_ctx[i] = 0; th_link[i] = psta_pkg::NIL;
      end
      for (int p = 0; p <= TOP_PRIORITY; p++) rdy_head[p] = psta_pkg::NIL;
      sleep_list = psta_pkg::NIL;
      cur_slot = 0;
      th_tid[0] = 1;
      th_st[0] = psta_pkg::ST_RUNNING;
      tid_counter = 2;
      lim_age = 19; unit_slice = 2; ms_div = 10;

      rows = '{
         '{psta_pkg::OP_QUERY, 8'd0, 64'd0, 64'd0, 32'd0, 32'd1, 1, 1'b0, 32'd0, 1'b1},
         '{psta_pkg::OP_QUERY, 8'd0, 64'd0, 64'd0, 32'd0, 32'd0, 1, 1'b0, 32'd0, 1'b0},
         '{psta_pkg::OP_QUERY, 8'd0, 64'd0, 64'd0, 32'd0, '1, 1, 1'b0, 32'd0, 1'b0},
         '{psta_pkg::OP_SPAWN, 8'hFF, '1, 64'd0, 32'd0, 32'd0, 1, 1'b0, 32'd2, 1'b0},
         '{psta_pkg::OP_SPAWN, 8'd0, 64'd0, 64'd0, 32'd0, 32'd0, 1, 1'b0, 32'd3, 1'b0},
         '{psta_pkg::OP_RESCHED, 8'd0, 64'hA5A5_5A5A_0F0F_F0F0, 64'd0, 32'd0, 32'd0,
           0, 0, 0, 0},
         '{OP_RSV5, '1, '1, '1, '1, '1, 1, 1'b0, 32'd0, 1'b0},
         '{OP_RSV6, '1, '1, '1, '1, '1, 1, 1'b0, 32'd0, 1'b0},
         '{OP_RSV7, '1, '1, '1, '1, '1, 1, 1'b0, 32'd0, 1'b0},
         '{psta_pkg::OP_SLEEP, 8'd0, 64'd0, 64'd0, '1, 32'd0, 0, 0, 0, 0},
         '{psta_pkg::OP_RESCHED, 8'd0, 64'h1234, 64'd5, 32'd0, 32'd0, 0, 0, 0, 0},
         '{psta_pkg::OP_EXIT, 8'd0, 64'd0, 64'd0, 32'd0, 32'd0, 0, 0, 0, 0},
         '{psta_pkg::OP_RESCHED, 8'd0, 64'h5678, '1, 32'd0, 32'd0, 0, 0, 0, 0},
         '{psta_pkg::OP_QUERY, 8'd0, 64'd0, 64'd0, 32'd0, 32'd2, 0, 0, 0, 0},
         '{psta_pkg::OP_SPAWN, 8'd3, 64'hDEAD, 64'd0, 32'd0, 32'd0, 1, 1'b0, 32'd4, 1'b0},
         '{psta_pkg::OP_RESCHED, 8'd0, 64'h9, 64'd10, 32'd0, 32'd0, 0, 0, 0, 0},
         '{psta_pkg::OP_EXIT, 8'd0, 64'd0, 64'd0, 32'd0, 32'd0, 0, 0, 0, 0},
         '{psta_pkg::OP_RESCHED, 8'd0, 64'hA, 64'd11, 32'd0, 32'd0, 0, 0, 0, 0},
         '{psta_pkg::OP_RESCHED, 8'd0, 64'hB, 64'd12, 32'd0, 32'd0, 0, 0, 0, 0},
         '{psta_pkg::OP_QUERY, 8'd0, 64'd0, 64'd0, 32'd0, 32'd4, 0, 0, 0, 0},
         '{psta_pkg::OP_SLEEP, 8'd0, 64'd0, 64'd100, 32'd0, 32'd0, 0, 0, 0, 0},
         '{psta_pkg::OP_RESCHED, 8'd0, 64'hC, 64'd100, 32'd0, 32'd0, 0, 0, 0, 0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         typed_res = '{default: '0};
         typed_res.status = rows[i].status;
         typed_res.tid = rows[i].tid;
         typed_res.alive = rows[i].alive;
         send_request(rows[i].op, rows[i].pri, rows[i].ctx, rows[i].now, rows[i].ms,
               rows[i].qtid, rows[i].typed, typed_res);
      end
      drain();
      sys_tick = 200;

      write_reg(psta_pkg::REG_AGING_LIMIT, 32'd3);
      write_reg(psta_pkg::REG_SLICE_UNIT, 32'd1);
      write_reg(psta_pkg::REG_MS_PER_TICK, 32'd1);
      gap_pct = 0; stall_pct = 0;
      random_requests(300);

      write_reg(psta_pkg::REG_AGING_LIMIT, 32'd255);
      write_reg(psta_pkg::REG_SLICE_UNIT, 32'd15);
      write_reg(psta_pkg::REG_MS_PER_TICK, 32'd255);
      gap_pct = 60; stall_pct = 0;
      random_requests(300);

      write_reg(psta_pkg::REG_AGING_LIMIT, 32'd0);
      write_reg(psta_pkg::REG_SLICE_UNIT, 32'd0);
      write_reg(psta_pkg::REG_MS_PER_TICK, 32'd0);
      gap_pct = 0; stall_pct = 60;
      random_requests(300);

      write_reg(psta_pkg::REG_AGING_LIMIT, 32'd19);
      write_reg(psta_pkg::REG_SLICE_UNIT, 32'd2);
      write_reg(psta_pkg::REG_MS_PER_TICK, 32'd10);
      gap_pct = 13; stall_pct = 13;
      random_requests(300);

      stall_pct = 0;
      repeat (200) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_results.size());
         errors++;
      end
      $display("Ran %0d requests over four pacing and register settings", n_items);
      $display("Context switches %0d, slots released %0d, full-table spawns %0d",
            n_switch, n_freed, n_full);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### sim.f
rtl/psta_pkg.sv
rtl/psta_div.sv
rtl/priority_thread_scheduler_aging.sv
sim/tb.sv
